@@ rtl/core/mods_pkg.sv @@
`timescale 1ns / 1ps

package mods_pkg;

  localparam int MAX_DIM_DEF = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int ELEM_W    = 32;
  localparam int SUM_W     = 37;
  localparam int ACC_W     = 38;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

endpackage

@@ rtl/core/mods_ram.sv @@
`timescale 1ns / 1ps

module mods_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/max_off_diagonal_sum_top.sv @@
`timescale 1ns / 1ps

// Largest off-main diagonal sum of a streamed matrix.
// Configuration: write row_count (index 0) and col_count (index 1) over the
// cfg channel while the block is idle; cfg_ready is always high. Each write
// restarts the current matrix. Counts above MAX_DIM act as MAX_DIM.
// Input: one element per transaction on elem_valid/elem_stall, row-major.
// A transaction can be taken every cycle while elem_stall is low. If either
// count is zero the elements are consumed and ignored.
// Output: one max_sum transaction per matrix, valid once the final element
// has passed the s1 stage and the output register. Diagonal sums live in a
// RAM of 2*MAX_DIM-1 entries; the read at acceptance and the write back in
// the following cycle set the single-cycle rate. A skid register holds a
// second result while the receiver stalls; elem_stall is raised only when
// both result slots would be full.
// Reset: synchronous rst clears counts, position, running maximum and all
// pending results. RAM contents need no clearing.
module max_off_diagonal_sum_top #(
  parameter int MAX_DIM = mods_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                elem_valid,
  output logic                                elem_stall,
  input  logic signed [mods_pkg::ELEM_W-1:0]  element,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [mods_pkg::SUM_W-1:0]          max_sum,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mods_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mods_pkg::CFG_W-1:0]          cfg_data
);

  localparam int IDX_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int CNT_W    = ($clog2(MAX_DIM + 1) > mods_pkg::CFG_W) ?
                            $clog2(MAX_DIM + 1) : mods_pkg::CFG_W;
  localparam int NUM_DIAG = 2 * MAX_DIM - 1;
  localparam int AW       = (NUM_DIAG > 1) ? $clog2(NUM_DIAG) : 1;
  localparam int ACC_W    = mods_pkg::ACC_W;
  localparam int ELEM_W   = mods_pkg::ELEM_W;
  localparam int SUM_W    = mods_pkg::SUM_W;

  logic [mods_pkg::CFG_W-1:0] row_count;
  logic [mods_pkg::CFG_W-1:0] col_count;
  logic [IDX_W-1:0]           row_index;
  logic [IDX_W-1:0]           col_index;

  logic [CNT_W-1:0] rows;
  logic [CNT_W-1:0] cols;
  logic             empty;
  logic             accept;
  logic             work;
  logic             cfg_accept;
  logic             row_last;
  logic             col_last;
  logic [AW-1:0]    diag_addr;

  logic                     s1_valid;
  logic                     s1_first;
  logic                     s1_last;
  logic                     s1_end;
  logic [AW-1:0]            s1_addr;
  logic signed [ELEM_W-1:0] s1_elem;

  logic [ACC_W-1:0]        rd_raw;
  logic signed [ACC_W-1:0] rd_data;
  logic signed [ACC_W-1:0] elem_ext;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] best_sum;
  logic signed [ACC_W-1:0] best_cand;
  logic                    res_valid;
  logic [SUM_W-1:0]        res_val;

  logic             skid_valid;
  logic [SUM_W-1:0] skid_sum;
  logic             out_free;

  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid & cfg_ready;

  assign rows = (CNT_W'(row_count) > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(row_count);
  assign cols = (CNT_W'(col_count) > CNT_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(col_count);
  assign empty = (rows == '0) || (cols == '0);

  assign accept = elem_valid & ~elem_stall;
  assign work   = accept & ~empty;

  assign row_last  = CNT_W'(row_index) == (rows - CNT_W'(1));
  assign col_last  = CNT_W'(col_index) == (cols - CNT_W'(1));
  assign diag_addr = AW'(col_index) + AW'(MAX_DIM - 1) - AW'(row_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
      row_index <= '0;
      col_index <= '0;
    end else if (cfg_accept) begin
      unique case (cfg_index)
        mods_pkg::REG_ROW_COUNT: row_count <= cfg_data;
        mods_pkg::REG_COL_COUNT: col_count <= cfg_data;
      endcase
      row_index <= '0;
      col_index <= '0;
    end else if (work) begin
      if (col_last) begin
        col_index <= '0;
        row_index <= row_last ? '0 : row_index + IDX_W'(1);
      end else begin
        col_index <= col_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= work;
    end
    if (work) begin
      s1_first <= (row_index == '0) || (col_index == '0);
      s1_last  <= (row_index != col_index) && (row_last || col_last);
      s1_end   <= row_last && col_last;
      s1_addr  <= diag_addr;
      s1_elem  <= element;
    end
  end

  mods_ram #(
    .WIDTH (ACC_W),
    .DEPTH (NUM_DIAG)
  ) u_diag_ram (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_addr),
    .wdata (acc_sum),
    .re    (work),
    .raddr (diag_addr),
    .rdata (rd_raw)
  );

  // same diagonal recurs no sooner than three transactions later, so the
  // write back always lands before the next read of that entry
  assign rd_data  = $signed(rd_raw);
  assign elem_ext = {{(ACC_W - ELEM_W){s1_elem[ELEM_W-1]}}, s1_elem};
  assign acc_sum  = s1_first ? elem_ext : rd_data + elem_ext;

  assign best_cand = (s1_last && (acc_sum > best_sum)) ? acc_sum : best_sum;
  assign res_valid = s1_valid & s1_end;
  assign res_val   = best_cand[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst || cfg_accept) begin
      best_sum <= '0;
    end else if (s1_valid) begin
      best_sum <= s1_end ? '0 : best_cand;
    end
  end

  assign out_free   = ~result_valid | ~result_stall;
  assign elem_stall = skid_valid | (s1_valid & s1_end & ~out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        max_sum      <= skid_sum;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= res_valid;
        max_sum      <= res_val;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
      skid_sum   <= res_val;
    end
  end

endmodule

@@ rtl/core/mods_checker.sv @@
`timescale 1ns / 1ps

module mods_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         elem_stall,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic [mods_pkg::SUM_W-1:0]   max_sum
);

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(max_sum))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  // input backs off only with a result already waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    elem_stall |-> result_valid)
    else $error("input stalled with output empty");

endmodule

bind max_off_diagonal_sum_top mods_checker u_mods_checker (
  .clk          (clk),
  .rst          (rst),
  .elem_stall   (elem_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .max_sum      (max_sum)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  import mods_pkg::*;

  localparam int MAX_DIM   = MAX_DIM_DEF;
  localparam int NUM_DIAG  = 2 * MAX_DIM - 1;
  localparam int TAIL_WAIT = 4;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                elem_valid = 1'b0;
  logic                elem_stall;
  logic [ELEM_W-1:0]   element = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  logic [SUM_W-1:0]    max_sum;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROW_COUNT;
  logic [CFG_W-1:0]    cfg_data = '0;

  max_off_diagonal_sum_top u_top (
    .clk          (clk),
    .rst          (rst),
    .elem_valid   (elem_valid),
    .elem_stall   (elem_stall),
    .element      (element),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .max_sum      (max_sum),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  logic [ELEM_W-1:0] element_queue[$];
  logic [SUM_W-1:0]  expected_max_sums[$];
  int                errors = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  bit                hold_armed = 1'b0;
  bit                hold_used = 1'b0;
  int                hold_left = 0;

  // diagonal-sum predictor
  logic [CFG_W-1:0]        row_count_reg = '0;
  logic [CFG_W-1:0]        col_count_reg = '0;
  int unsigned             row_pos = 0;
  int unsigned             col_pos = 0;
  logic signed [ACC_W-1:0] diag_acc [0:NUM_DIAG-1];
  logic signed [ACC_W-1:0] best_acc = '0;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : int'(v);
  endfunction

  task automatic restart_matrix();
    row_pos = 0;
    col_pos = 0;
    best_acc = '0;
  endtask

  task automatic apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_W-1:0] data);
    case (idx)
      REG_ROW_COUNT: begin
        row_count_reg = data;
        restart_matrix();
      end
      REG_COL_COUNT: begin
        col_count_reg = data;
        restart_matrix();
      end
      default: ;
    endcase
  endtask

  task automatic accumulate_element(input logic signed [ELEM_W-1:0] value);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    int unsigned d;
    rows = clamp_dim(row_count_reg);
    cols = clamp_dim(col_count_reg);
    if (rows == 0 || cols == 0) return;
    r = row_pos;
    c = col_pos;
    d = c + MAX_DIM - 1 - r;
    if (r == 0 || c == 0) diag_acc[d] = value;
    else diag_acc[d] = diag_acc[d] + value;
    if (r != c && (r == rows - 1 || c == cols - 1) && diag_acc[d] > best_acc)
      best_acc = diag_acc[d];
    if (c + 1 < cols) begin
      col_pos = c + 1;
    end else if (r + 1 < rows) begin
      col_pos = 0;
      row_pos = r + 1;
    end else begin
      expected_max_sums.push_back(best_acc[SUM_W-1:0]);
      restart_matrix();
    end
  endtask

  // element driver
  always @(posedge clk) begin
    if (rst) begin
      elem_valid <= 1'b0;
    end else if (!elem_valid || !elem_stall) begin
      if (element_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        elem_valid <= 1'b1;
        element    <= element_queue.pop_front();
      end else begin
        elem_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (hold_armed && !hold_used) begin
      result_stall <= 1'b1;
      hold_left    <= 300;
      hold_used    <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    logic [SUM_W-1:0] want;
    if (rst) begin
      row_count_reg = '0;
      col_count_reg = '0;
      restart_matrix();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (elem_valid && !elem_stall) accumulate_element(element);
      if (result_valid && !result_stall) begin
        if (expected_max_sums.size() == 0) begin
          $error("max_sum: no transaction expected, actual %0d", max_sum);
          errors++;
        end else begin
          want = expected_max_sums.pop_front();
          if (max_sum !== want) begin
            $error("max_sum: expected %0d, actual %0d", want, max_sum);
            errors++;
          end
        end
      end
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (element_queue.size() != 0 || elem_valid || expected_max_sums.size() != 0);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(data);
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  task automatic set_dims(input int rows, input int cols);
    wait_idle();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [ELEM_W-1:0] pick_element(input int bias);
    int unsigned sel;
    sel = $urandom_range(15);
    case (sel)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: ;
    endcase
    if (bias == 1) return {1'b0, 31'($urandom)};
    if (bias == 2) return {1'b1, 31'($urandom)};
    return $urandom;
  endfunction

  task automatic push_elements(input int count, input int bias);
    repeat (count) element_queue.push_back(pick_element(bias));
  endtask

  initial begin
    int n_items;
    int n_mats;
    int rows;
    int cols;
    int size;
    int sel;
    int mats;
    n_items = 0;
    n_mats  = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 58;
    // counts are zero out of reset: elements are swallowed
    element_queue.push_back(32'h7FFF_FFFF);
    element_queue.push_back(32'h8000_0000);
    // single element sits on the main diagonal
    set_dims(1, 1);
    element_queue.push_back(32'h7FFF_FFFF);
    set_dims(1, 2);
    element_queue.push_back(32'hFFFF_FFFB);
    element_queue.push_back(32'h7FFF_FFFF);
    set_dims(2, 1);
    element_queue.push_back(32'h8000_0000);
    element_queue.push_back(32'h0000_0007);
    set_dims(2, 2);
    repeat (4) element_queue.push_back(32'h7FFF_FFFF);
    // all sums negative, maximum stays at zero
    set_dims(2, 3);
    repeat (6) element_queue.push_back(32'h8000_0000);
    // part of a matrix, then a single write restarts it
    element_queue.push_back(32'h0000_0009);
    element_queue.push_back(32'h7FFF_FFFF);
    element_queue.push_back(32'h0000_0005);
    wait_idle();
    write_reg(REG_COL_COUNT, 2);
    cfg_valid <= 1'b0;
    for (int i = 1; i <= 4; i++) element_queue.push_back(ELEM_W'(i));
    set_dims(127, 0);
    element_queue.push_back(32'h0000_0001);

    // back-pressure: one result per element while the receiver holds off
    set_dims(1, 1);
    send_idle_pct = 0;
    hold_armed = 1'b1;
    push_elements(40, 1);
    n_items += 40;
    n_mats  += 40;

    // largest sizes, including counts clamped to the maximum
    send_idle_pct = 20;
    set_dims(127, 2);
    push_elements(MAX_DIM * 2, 1);
    set_dims(3, MAX_DIM);
    push_elements(MAX_DIM * 3, 0);
    n_items += MAX_DIM * 5;
    n_mats  += 2;

    while (n_items < 950 || n_mats < 60) begin
      if (n_items < 317) begin
        send_idle_pct = 20;
        recv_idle_pct = 58;
      end else if (n_items < 634) begin
        send_idle_pct = 58;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sel = $urandom_range(99);
      if (sel < 4) begin
        rows = $urandom_range(1) ? 0 : $urandom_range(127);
        cols = (rows == 0) ? $urandom_range(127) : 0;
        set_dims(rows, cols);
        push_elements($urandom_range(1, 4), 0);
        continue;
      end
      if (sel < 9) begin
        rows = $urandom_range(1) ? MAX_DIM : $urandom_range(MAX_DIM + 1, 127);
        cols = $urandom_range(1, 2);
        if ($urandom_range(1)) begin
          size = rows;
          rows = cols;
          cols = size;
        end
        mats = 1;
      end else begin
        rows = $urandom_range(1, 6);
        cols = $urandom_range(1, 6);
        mats = $urandom_range(1, 4);
      end
      set_dims(rows, cols);
      size = clamp_dim(CFG_W'(rows)) * clamp_dim(CFG_W'(cols));
      repeat (mats) push_elements(size, $urandom_range(2));
      n_items += size * mats;
      n_mats  += mats;
      if (size > 1 && $urandom_range(99) < 15) begin
        sel = $urandom_range(1, size - 1);
        push_elements(sel, 0);
        n_items += sel;
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ max_off_diagonal_sum_top.f @@
rtl/core/mods_pkg.sv
rtl/core/mods_ram.sv
rtl/core/max_off_diagonal_sum_top.sv
rtl/core/mods_checker.sv
test/testbench.sv
